// File: rtl/mawc_pkg.sv
// Shared constants and types for the wrap-corrected moving average.
`default_nettype none

package mawc_pkg;

	localparam int MAX_WINDOW = 8;
	localparam int IDX_W      = $clog2(MAX_WINDOW);
	localparam int FILL_W     = $clog2(MAX_WINDOW + 1);

	localparam int SAMPLE_W    = 32;
	localparam int SIZE_W      = 4;
	localparam int CFG_W       = 30;
	localparam int CFG_IDX_W   = 2;
	localparam int OUT_W       = 40;
	localparam int FRAC_W      = 8;

	localparam int SUM_W       = SAMPLE_W + IDX_W;
	localparam int DIV_W       = SUM_W + FRAC_W;
	localparam int DIV_CNT_W   = $clog2(DIV_W + 1);
	localparam int CORR_CNT_W  = FILL_W;
	localparam int CORR_W      = CORR_CNT_W + CFG_W + 1;
	localparam int CMP_W       = SAMPLE_W + 2;
	localparam int RES_A_W     = (DIV_W + 1 > CORR_W + FRAC_W) ? DIV_W + 1 : CORR_W + FRAC_W;
	localparam int RES_W       = RES_A_W + 1;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE     = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_WRAP_THRESHOLD  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_CORRECTION_STEP = CFG_IDX_W'(2);

	localparam logic [SIZE_W-1:0] WINDOW_SIZE_RST     = SIZE_W'(3);
	localparam logic [CFG_W-1:0]  WRAP_THRESHOLD_RST  = CFG_W'(30);
	localparam logic [CFG_W-1:0]  CORRECTION_STEP_RST = CFG_W'(20);

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  dividend;
		logic [FILL_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

// File: rtl/mawc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module mawc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]              rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// File: rtl/mawc_div.sv
// Bit-serial restoring divider of the scaled sum magnitude by the fill count.
`default_nettype none

module mawc_div
	import mawc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     quo_q;
	logic [FILL_W-1:0]    rem_q;
	logic [FILL_W-1:0]    dvs_q;
	logic [FILL_W:0]      trial_c;
	logic [FILL_W:0]      diff_c;
	logic                 fits_c;

	assign trial_c = {rem_q, quo_q[DIV_W-1]};
	assign fits_c  = trial_c >= {1'b0, dvs_q};
	assign diff_c  = trial_c - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !req.start && busy_q && (cnt_q == DIV_CNT_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], fits_c};
			rem_q <= fits_c ? diff_c[FILL_W-1:0] : trial_c[FILL_W-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

// File: rtl/moving_average_wrap_corrected.sv
// Top level of the boxcar moving average with wrap correction.
`default_nettype none

// Each accepted sample is written into an eight-entry window RAM, and one result word
// follows per sample. The sequencer reads the filled entries newest first, through a read
// state and an accumulate state per entry, summing them and counting neighbor wraps, and
// then a bit-serial divider takes one quotient bit per cycle, 43 bits in all. The next
// sample is accepted as soon as a result has moved to the output register, even while
// that word still waits. Configuration must be written only while no sample is in flight;
// the block itself does not enforce it.
module moving_average_wrap_corrected
	import mawc_pkg::*;
(
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic signed [SAMPLE_W-1:0]  sample,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic signed [OUT_W-1:0]          filtered_value,
	output logic [FILL_W-1:0]                window_fill,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [CFG_W-1:0]            cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_ACC,
		ST_DIV,
		ST_FIN
	} state_t;

	localparam int WS_EXT_W = (SIZE_W > FILL_W) ? SIZE_W : FILL_W;
	localparam logic signed [RES_W-1:0] OUT_MAX_R =
		$signed({{(RES_W - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}});
	localparam logic signed [RES_W-1:0] OUT_MIN_R =
		$signed({{(RES_W - OUT_W + 1){1'b1}}, {(OUT_W - 1){1'b0}}});

	state_t                        state_q;
	logic [SIZE_W-1:0]             window_size_q;
	logic [CFG_W-1:0]              wrap_threshold_q;
	logic [CFG_W-1:0]              correction_step_q;
	logic [IDX_W-1:0]              wr_idx_q;
	logic [FILL_W-1:0]             fill_q;
	logic [FILL_W-1:0]             size_q;
	logic [IDX_W-1:0]              pos_q;
	logic [FILL_W-1:0]             cnt_q;
	logic                          first_q;
	logic signed [SUM_W-1:0]       sum_q;
	logic signed [SAMPLE_W-1:0]    prev_q;
	logic signed [CORR_CNT_W-1:0]  corr_cnt_q;
	logic signed [CORR_W-1:0]      corr_q;
	logic signed [DIV_W:0]         quot_q;
	logic                          div_start_q;
	logic                          out_valid_q;
	logic signed [OUT_W-1:0]       filtered_value_q;
	logic [FILL_W-1:0]             window_fill_q;

	logic                          in_accept_c;
	logic [WS_EXT_W-1:0]           ws_ext_c;
	logic [FILL_W-1:0]             size_c;
	logic [IDX_W-1:0]              wi_c;
	logic [FILL_W-1:0]             wi_inc_c;
	logic [FILL_W-1:0]             fill_clamp_c;
	logic [FILL_W-1:0]             fill_c;
	logic [SAMPLE_W-1:0]           ram_rdata;
	logic signed [SAMPLE_W-1:0]    rdata_s;
	logic signed [CMP_W-1:0]       diff_c;
	logic signed [CMP_W-1:0]       thr_c;
	logic                          wrap_up_c;
	logic                          wrap_dn_c;
	logic [SUM_W-1:0]              mag_c;
	logic signed [RES_W-1:0]       res_c;
	logic signed [OUT_W-1:0]       sat_c;
	div_req_t                      div_req;
	div_rsp_t                      div_rsp;

	assign in_accept_c = in_valid && !in_stall;
	assign ws_ext_c    = WS_EXT_W'(window_size_q);

	always_comb begin
		if (ws_ext_c == '0) begin
			size_c = FILL_W'(1);
		end else if (ws_ext_c > WS_EXT_W'(MAX_WINDOW)) begin
			size_c = FILL_W'(MAX_WINDOW);
		end else begin
			size_c = FILL_W'(ws_ext_c);
		end
		wi_c         = (FILL_W'(wr_idx_q) >= size_c) ? '0 : wr_idx_q;
		wi_inc_c     = FILL_W'(wi_c) + FILL_W'(1);
		fill_clamp_c = (fill_q > size_c) ? size_c : fill_q;
		fill_c       = (fill_clamp_c < size_c) ? fill_clamp_c + FILL_W'(1) : fill_clamp_c;
	end

	mawc_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(MAX_WINDOW)
	) u_store (
		.clk    (clk),
		.wr_en  (in_accept_c),
		.wr_addr(wi_c),
		.wr_data(sample),
		.rd_addr(pos_q),
		.rd_data(ram_rdata)
	);

	assign rdata_s   = ram_rdata;
	assign diff_c    = CMP_W'(prev_q) - CMP_W'(rdata_s);
	assign thr_c     = CMP_W'($signed({1'b0, wrap_threshold_q}));
	assign wrap_up_c = diff_c > thr_c;
	assign wrap_dn_c = diff_c < -thr_c;

	assign mag_c = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

	assign div_req.start    = div_start_q;
	assign div_req.dividend = {mag_c, {FRAC_W{1'b0}}};
	assign div_req.divisor  = fill_q;

	mawc_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	always_comb begin
		res_c = RES_W'(quot_q) + RES_W'($signed({corr_q, {FRAC_W{1'b0}}}));
		if (res_c > OUT_MAX_R) begin
			sat_c = OUT_MAX_R[OUT_W-1:0];
		end else if (res_c < OUT_MIN_R) begin
			sat_c = OUT_MIN_R[OUT_W-1:0];
		end else begin
			sat_c = res_c[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q     <= WINDOW_SIZE_RST;
			wrap_threshold_q  <= WRAP_THRESHOLD_RST;
			correction_step_q <= CORRECTION_STEP_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WINDOW_SIZE:     window_size_q     <= cfg_data[SIZE_W-1:0];
				REG_WRAP_THRESHOLD:  wrap_threshold_q  <= cfg_data;
				REG_CORRECTION_STEP: correction_step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wr_idx_q    <= '0;
			fill_q      <= '0;
			cnt_q       <= '0;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			div_start_q <= (state_q == ST_ACC) && (cnt_q == FILL_W'(1));
			if (out_valid_q && !out_stall && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept_c) begin
						size_q     <= size_c;
						fill_q     <= fill_c;
						cnt_q      <= fill_c;
						pos_q      <= wi_c;
						wr_idx_q   <= (wi_inc_c == size_c) ? '0 : wi_inc_c[IDX_W-1:0];
						first_q    <= 1'b1;
						sum_q      <= '0;
						corr_cnt_q <= '0;
						state_q    <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					sum_q   <= sum_q + SUM_W'(rdata_s);
					prev_q  <= rdata_s;
					first_q <= 1'b0;
					if (!first_q && wrap_up_c) begin
						corr_cnt_q <= corr_cnt_q + CORR_CNT_W'(1);
					end else if (!first_q && wrap_dn_c) begin
						corr_cnt_q <= corr_cnt_q - CORR_CNT_W'(1);
					end
					pos_q <= (pos_q == '0) ? IDX_W'(size_q - FILL_W'(1)) : pos_q - IDX_W'(1);
					cnt_q <= cnt_q - FILL_W'(1);
					if (cnt_q == FILL_W'(1)) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_DIV: begin
					corr_q <= CORR_W'(corr_cnt_q) * CORR_W'($signed({1'b0, correction_step_q}));
					if (div_rsp.done) begin
						quot_q  <= sum_q[SUM_W-1] ? -$signed({1'b0, div_rsp.quotient})
							: $signed({1'b0, div_rsp.quotient});
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!out_valid_q || !out_stall) begin
						filtered_value_q <= sat_c;
						window_fill_q    <= fill_q;
						out_valid_q      <= 1'b1;
						state_q          <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall       = (state_q != ST_IDLE);
	assign cfg_ready      = 1'b1;
	assign out_valid      = out_valid_q;
	assign filtered_value = filtered_value_q;
	assign window_fill    = window_fill_q;

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(MAX_WINDOW))
		else $error("Fill count exceeds the window depth.");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIV)
		else $error("Divider finished outside the divide step.");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept_c |=> in_stall && fill_q != '0)
		else $error("Sequencer did not start after a word was accepted.");

	a_out_fill_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> window_fill != '0 && window_fill <= FILL_W'(MAX_WINDOW))
		else $error("Result word carries an impossible fill count.");

endmodule

`default_nettype wire

// File: dv/mawc_checker.sv
// Checker for the wrap-corrected moving average: predicts each result word and compares it.
module mawc_checker
	import mawc_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic signed [OUT_W-1:0]    filtered_value,
	input  logic [FILL_W-1:0]          window_fill,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	output int                         fail_count,
	output int                         pending,
	output int                         checked_count,
	output int                         corrected_count,
	output int                         saturated_count
);

	localparam longint AVG_MAX = (longint'(1) <<< (OUT_W - 1)) - 1;
	localparam longint AVG_MIN = -(longint'(1) <<< (OUT_W - 1));

	typedef struct packed {
		logic signed [OUT_W-1:0] value;
		logic [FILL_W-1:0]       fill;
	} avg_word_t;

	avg_word_t                 expected_avg_q[$];
	logic signed [SAMPLE_W-1:0] win_mem[MAX_WINDOW];
	int unsigned               wr_ptr;
	int unsigned               filled;
	logic [SIZE_W-1:0]         size_reg;
	logic [CFG_W-1:0]          thr_reg;
	logic [CFG_W-1:0]          step_reg;

	initial begin
		fail_count      = 0;
		pending         = 0;
		checked_count   = 0;
		corrected_count = 0;
		saturated_count = 0;
	end

	function automatic void clear_model();
		foreach (win_mem[k])
			win_mem[k] = '0;
		wr_ptr   = 0;
		filled   = 0;
		size_reg = WINDOW_SIZE_RST;
		thr_reg  = WRAP_THRESHOLD_RST;
		step_reg = CORRECTION_STEP_RST;
		expected_avg_q.delete();
	endfunction

	function automatic void average_sample(input logic signed [SAMPLE_W-1:0] s);
		int unsigned n;
		int unsigned pos;
		int unsigned prv;
		longint      acc;
		longint      corr;
		longint      diff;
		longint      thr;
		longint      res;
		avg_word_t   w;
		n = size_reg;
		if (n == 0)
			n = 1;
		if (n > MAX_WINDOW)
			n = MAX_WINDOW;
		if (wr_ptr >= n)
			wr_ptr = 0;
		win_mem[wr_ptr] = s;
		if (filled > n)
			filled = n;
		if (filled < n)
			filled++;
		thr  = longint'(thr_reg);
		acc  = 0;
		corr = 0;
		pos  = wr_ptr;
		prv  = 0;
		for (int unsigned k = 0; k < filled; k++) begin
			acc += longint'(win_mem[pos]);
			if (k > 0) begin
				diff = longint'(win_mem[prv]) - longint'(win_mem[pos]);
				if (diff > thr)
					corr += longint'(step_reg);
				else if (diff < -thr)
					corr -= longint'(step_reg);
			end
			prv = pos;
			pos = (pos == 0) ? n - 1 : pos - 1;
		end
		wr_ptr = (wr_ptr + 1) % n;
		res = (acc * 256) / longint'(filled) + corr * 256;
		if (corr != 0)
			corrected_count++;
		if (res > AVG_MAX) begin
			res = AVG_MAX;
			saturated_count++;
		end else if (res < AVG_MIN) begin
			res = AVG_MIN;
			saturated_count++;
		end
		w.value = OUT_W'(res);
		w.fill  = FILL_W'(filled);
		expected_avg_q.push_back(w);
	endfunction

	task automatic check_word();
		avg_word_t w;
		if (expected_avg_q.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("mawc_checker: unexpected word, value %0d fill %0d",
					filtered_value, window_fill);
		end else begin
			w = expected_avg_q.pop_front();
			checked_count++;
			if (filtered_value !== w.value || window_fill !== w.fill) begin
				fail_count++;
				if (fail_count <= 10)
					$display("mawc_checker: word %0d expected value %0d fill %0d, got value %0d fill %0d",
						checked_count, w.value, w.fill, filtered_value, window_fill);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_model();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WINDOW_SIZE:     size_reg = cfg_data[SIZE_W-1:0];
					REG_WRAP_THRESHOLD:  thr_reg  = cfg_data;
					REG_CORRECTION_STEP: step_reg = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall)
				check_word();
			if (in_valid && !in_stall)
				average_sample(sample);
			pending <= expected_avg_q.size();
		end
	end

endmodule

// File: dv/tb_top.sv
// Testbench top for the wrap-corrected moving average: clock, reset, stimulus and verdict.
module tb_top;
	import mawc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);
	localparam logic [SAMPLE_W-1:0]  S_MAX      = 32'h7fff_ffff;
	localparam logic [SAMPLE_W-1:0]  S_MIN      = 32'h8000_0000;
	localparam logic [SAMPLE_W-1:0]  S_ONES     = 32'hffff_ffff;
	localparam logic [SIZE_W-1:0]    SIZE_TOP   = 4'hf;
	localparam int                   DIRECTED_N = 25;
	localparam int                   RANDOM_N   = 500;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic [SAMPLE_W-1:0]   sample    = '0;
	logic                  out_stall = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_WINDOW_SIZE;
	logic [CFG_W-1:0]      cfg_data  = '0;
	logic                  in_stall;
	logic                  out_valid;
	logic signed [OUT_W-1:0] filtered_value;
	logic [FILL_W-1:0]     window_fill;
	logic                  cfg_ready;

	int mismatches;
	int pending;
	int checked;
	int corrected;
	int saturated;

	int                  items_sent  = 0;
	int                  phases      = 0;
	int                  burst_left  = 0;
	bit                  no_gaps     = 1'b1;
	logic [SAMPLE_W-1:0] last_sample = '0;
	logic [CFG_W-1:0]    cur_thr     = WRAP_THRESHOLD_RST;

	moving_average_wrap_corrected u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.sample         (sample),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.filtered_value (filtered_value),
		.window_fill    (window_fill),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	mawc_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.sample          (sample),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.filtered_value  (filtered_value),
		.window_fill     (window_fill),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.fail_count      (mismatches),
		.pending         (pending),
		.checked_count   (checked),
		.corrected_count (corrected),
		.saturated_count (saturated)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

	// The receiver switches between free running, random stalls, heavy stalls and full stops.
	initial begin
		int unsigned mode;
		int unsigned span;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 200);
			repeat (span) begin
				@(posedge clk);
				case (mode)
					0:       out_stall <= 1'b0;
					1:       out_stall <= 1'($urandom_range(0, 1));
					2:       out_stall <= ($urandom_range(0, 9) != 0);
					default: out_stall <= 1'b1;
				endcase
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == REG_WRAP_THRESHOLD)
			cur_thr = val;
	endtask

	task automatic send_sample(input logic [SAMPLE_W-1:0] s);
		int unsigned gap;
		sample   <= s;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
		last_sample = s;
		if (burst_left > 0) begin
			burst_left--;
		end else if (!no_gaps) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 80) : $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap)
				@(posedge clk);
			burst_left = $urandom_range(0, 7);
		end
	endtask

	// Every word has left the block once the checker holds no expectation.
	task automatic end_phase();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		phases++;
	endtask

	function automatic logic [CFG_W-1:0] pick_level();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			2:       return CFG_W'($urandom_range(0, 200));
			3:       return CFG_W'($urandom_range(0, 100000));
			default: return CFG_W'($urandom);
		endcase
	endfunction

	task automatic random_config();
		logic [CFG_W-1:0] v;
		bit               wrote;
		wrote = 1'b0;
		if ($urandom_range(0, 3) != 0) begin
			v = CFG_W'($urandom);
			case ($urandom_range(0, 5))
				0:       v[SIZE_W-1:0] = '0;
				1:       v[SIZE_W-1:0] = SIZE_W'(1);
				2:       v[SIZE_W-1:0] = SIZE_W'(MAX_WINDOW);
				3:       v[SIZE_W-1:0] = SIZE_TOP;
				default: v[SIZE_W-1:0] = SIZE_W'($urandom_range(0, 15));
			endcase
			write_reg(REG_WINDOW_SIZE, v);
			wrote = 1'b1;
		end
		if ($urandom_range(0, 2) != 0) begin
			write_reg(REG_WRAP_THRESHOLD, pick_level());
			wrote = 1'b1;
		end
		if ($urandom_range(0, 2) != 0) begin
			write_reg(REG_CORRECTION_STEP, pick_level());
			wrote = 1'b1;
		end
		if ($urandom_range(0, 5) == 0) begin
			write_reg(REG_UNUSED, CFG_W'($urandom));
			wrote = 1'b1;
		end
		if (wrote)
			cfg_valid <= 1'b0;
	endtask

	// Most samples step from the previous one by about the threshold so that wraps show up.
	function automatic logic [SAMPLE_W-1:0] next_sample();
		int unsigned span;
		span = (cur_thr > 30'd800000000) ? 32'd1000000000 : cur_thr + cur_thr / 4 + 4;
		case ($urandom_range(0, 9))
			0, 1: return $urandom;
			2: begin
				case ($urandom_range(0, 3))
					0:       return S_MAX;
					1:       return S_MIN;
					2:       return '0;
					default: return S_ONES;
				endcase
			end
			3: begin
				if ($urandom_range(0, 1))
					return last_sample + cur_thr + $urandom_range(0, 1);
				else
					return last_sample - cur_thr - $urandom_range(0, 1);
			end
			default: return last_sample + $urandom_range(0, 2 * span) - span;
		endcase
	endfunction

	initial begin
		logic [SAMPLE_W-1:0] steps[12];
		int unsigned         run_len;
		steps = '{32'd0, S_ONES, S_MAX, S_MIN, S_MAX, S_MIN,
			32'd100, 32'd131, 32'd161, 32'd131, 32'd100, 32'd5};

		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A full window first, so that no later enlargement reaches an entry never written.
		write_reg(REG_WINDOW_SIZE, CFG_W'(MAX_WINDOW));
		cfg_valid <= 1'b0;
		foreach (steps[k])
			send_sample(steps[k]);
		end_phase();

		// Oversized window, zero threshold and the largest step drive the result into saturation.
		write_reg(REG_WINDOW_SIZE, CFG_W'(SIZE_TOP));
		write_reg(REG_WRAP_THRESHOLD, '0);
		write_reg(REG_CORRECTION_STEP, '1);
		cfg_valid <= 1'b0;
		for (int k = 0; k < 10; k++)
			send_sample(k < 6 ? SAMPLE_W'(k * 1000) : SAMPLE_W'(-k * 1000));
		end_phase();

		// A zero window acts as one sample and shrinks below both the pointer and the fill.
		write_reg(REG_WINDOW_SIZE, '0);
		write_reg(REG_WRAP_THRESHOLD, '1);
		write_reg(REG_CORRECTION_STEP, '0);
		write_reg(REG_UNUSED, CFG_W'($urandom));
		cfg_valid <= 1'b0;
		send_sample(S_MIN);
		send_sample(S_MAX);
		send_sample(32'd7);
		end_phase();

		while (items_sent < DIRECTED_N + RANDOM_N) begin
			random_config();
			no_gaps    = ($urandom_range(0, 3) == 0);
			burst_left = $urandom_range(0, 7);
			run_len    = $urandom_range(10, 60);
			repeat (run_len)
				send_sample(next_sample());
			end_phase();
		end

		repeat (100)
			@(posedge clk);
		$display("tb_top: %0d samples over %0d setting phases, %0d result words compared.",
			items_sent, phases, checked);
		$display("tb_top: %0d words carried wrap corrections, %0d were clipped to 40 bits.",
			corrected, saturated);
		if (mismatches == 0 && pending == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

// File: moving_average_wrap_corrected.f
rtl/mawc_pkg.sv
rtl/mawc_ram.sv
rtl/mawc_div.sv
rtl/moving_average_wrap_corrected.sv
dv/mawc_checker.sv
dv/tb_top.sv
